// File: src/mwss_pkg.sv
// shared constants, types and the quarter-wave sine table of the wheel speed solver
package mwss_pkg;

    localparam int SINE_DEPTH = 256;
    localparam int IDX_W      = $clog2(SINE_DEPTH + 1);

    // configuration register indexes
    localparam logic [2:0] CFG_STEP_X = 3'd0;
    localparam logic [2:0] CFG_STEP_Y = 3'd1;
    localparam logic [2:0] CFG_WBASE  = 3'd2;
    localparam logic [2:0] CFG_WTRACK = 3'd3;
    localparam logic [2:0] CFG_OFS_X  = 3'd4;
    localparam logic [2:0] CFG_OFS_Y  = 3'd5;
    localparam logic [2:0] CFG_SCALE  = 3'd6;

    // serial multiplier: signed a times b, one bit of b per cycle
    localparam int MUL_A_W   = 30;
    localparam int MUL_B_W   = 24;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // serial divider: one quotient bit per cycle
    localparam int DIV_N_W   = 43;
    localparam int DIV_Q_W   = 16;
    localparam int DIV_D_W   = 27;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W);

    localparam logic [DIV_D_W-1:0] ANGLE_DIV = 27'd9000;
    localparam logic [DIV_D_W-1:0] RPM_DIV   = 27'd131072000;

    localparam logic signed [MUL_P_W:0] RPM_ROUND = 55'sd65536000;
    localparam logic signed [MUL_P_W:0] RPM_SAT   = 55'sd4294967296000;

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef logic [14:0] t_sine_tab [SINE_DEPTH+1];

    typedef struct packed {
        logic signed [27:0] term;
        logic               negate;
        logic signed [14:0] lever;
    } t_lane_cmd;

    // sin over 0..90 degrees, taylor series in Q2.30 rounded to unsigned Q0.15
    function automatic t_sine_tab f_sine_tab();
        t_sine_tab       tab;
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint          q;
        for (int i = 0; i <= SINE_DEPTH; i++) begin
            x    = (PI_Q30 * 64'(i)) / 64'(2 * SINE_DEPTH);
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 7; k++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * k) * (2 * k + 1));
                if ((k & 1) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            q = (sum + 64'sd16384) >>> 15;
            if (q > 32767) q = 32767;
            if (q < 0) q = 0;
            tab[i] = 15'(q);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = f_sine_tab();

endpackage

// File: src/mwss_smul.sv
// bit-serial shift-add multiplier, signed a by signed or unsigned b
module mwss_smul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [mwss_pkg::MUL_A_W-1:0] i_a,
    input  logic        [mwss_pkg::MUL_B_W-1:0] i_b,
    input  logic                                 i_b_signed,
    output logic                                 o_done,
    output logic signed [mwss_pkg::MUL_P_W-1:0] o_p
);

    localparam int PW = mwss_pkg::MUL_P_W;
    localparam int BW = mwss_pkg::MUL_B_W;
    localparam int CW = mwss_pkg::MUL_CNT_W;

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic signed [PW-1:0] r_a;
    logic [BW-1:0]        r_b;
    logic                 r_sgn;
    logic signed [PW-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= PW'(i_a);
                r_b    <= i_b;
                r_sgn  <= i_b_signed;
                r_acc  <= '0;
            end else if (r_busy) begin
                // top bit of a signed b carries negative weight
                if (r_b[0]) begin
                    if (r_sgn && (r_cnt == CW'(BW - 1))) begin
                        r_acc <= r_acc - r_a;
                    end else begin
                        r_acc <= r_acc + r_a;
                    end
                end
                r_a   <= r_a <<< 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(BW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

// File: src/mwss_cdiv.sv
// restoring divider, one quotient bit per cycle, quotient must fit its width
module mwss_cdiv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mwss_pkg::DIV_N_W-1:0] i_n,
    input  logic [mwss_pkg::DIV_D_W-1:0] i_d,
    output logic                          o_done,
    output logic [mwss_pkg::DIV_Q_W-1:0] o_q
);

    localparam int NW = mwss_pkg::DIV_N_W;
    localparam int QW = mwss_pkg::DIV_Q_W;
    localparam int CW = mwss_pkg::DIV_CNT_W;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_rem;
    logic [NW-1:0] r_dsh;
    logic [QW-1:0] r_q;
    logic          w_ge;

    assign w_ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW - 1);
                r_rem  <= i_n;
                r_dsh  <= NW'(i_d) << (QW - 1);
                r_q    <= '0;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_q   <= {r_q[QW-2:0], w_ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

// File: src/mwss_wheel.sv
// one wheel lane: spin lever product, rpm scaling, rounding divide and saturation
module mwss_wheel (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  mwss_pkg::t_lane_cmd         i_cmd,
    input  logic signed [13:0]          i_spin,
    input  logic [23:0]                 i_scale,
    output logic                        o_done,
    output logic [15:0]                 o_rpm
);

    localparam int AW = mwss_pkg::MUL_A_W;
    localparam int BW = mwss_pkg::MUL_B_W;
    localparam int PW = mwss_pkg::MUL_P_W;
    localparam int NW = mwss_pkg::DIV_N_W;
    localparam int QW = mwss_pkg::DIV_Q_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_DIV
    } t_state;

    t_state               r_state;
    logic                 r_hi;
    logic                 r_lo;
    logic                 r_done;
    logic [15:0]          r_rpm;

    logic                 w_mul_start;
    logic signed [AW-1:0] w_mul_a;
    logic [BW-1:0]        w_mul_b;
    logic                 w_mul_sgn;
    logic                 w_mul_done;
    logic signed [PW-1:0] w_mul_p;
    logic signed [AW-1:0] w_term;
    logic signed [AW-1:0] w_lp;
    logic signed [AW-1:0] w_s;
    logic signed [PW:0]   w_n;
    logic                 w_hi;
    logic                 w_lo;
    logic signed [PW:0]   w_u;
    logic                 w_div_start;
    logic [NW-1:0]        w_div_n;
    logic                 w_div_done;
    logic [QW-1:0]        w_div_q;

    assign w_term = AW'(i_cmd.term);
    assign w_lp   = AW'(w_mul_p);
    assign w_s    = i_cmd.negate ? -(w_term + w_lp) : (w_term - w_lp);

    // shift into [0, 65536*d) so the divider only sees positive values
    assign w_n     = (PW + 1)'(w_mul_p) + mwss_pkg::RPM_ROUND;
    assign w_hi    = (w_n >= mwss_pkg::RPM_SAT);
    assign w_lo    = (w_n < -mwss_pkg::RPM_SAT);
    assign w_u     = w_n + mwss_pkg::RPM_SAT;
    assign w_div_n = (w_hi || w_lo) ? '0 : NW'(w_u);

    always_comb begin
        w_mul_start = 1'b0;
        w_mul_a     = AW'(i_spin);
        w_mul_b     = BW'(i_cmd.lever);
        w_mul_sgn   = 1'b1;
        if (i_start) begin
            w_mul_start = 1'b1;
        end else if (r_state == ST_MUL1 && w_mul_done) begin
            w_mul_start = 1'b1;
            w_mul_a     = w_s;
            w_mul_b     = i_scale;
            w_mul_sgn   = 1'b0;
        end
    end

    assign w_div_start = (r_state == ST_MUL2) && w_mul_done;

    mwss_smul u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mul_start),
        .i_a        (w_mul_a),
        .i_b        (w_mul_b),
        .i_b_signed (w_mul_sgn),
        .o_done     (w_mul_done),
        .o_p        (w_mul_p)
    );

    mwss_cdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_n     (w_div_n),
        .i_d     (mwss_pkg::RPM_DIV),
        .o_done  (w_div_done),
        .o_q     (w_div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_start) r_state <= ST_MUL1;
                end
                ST_MUL1: begin
                    if (w_mul_done) r_state <= ST_MUL2;
                end
                ST_MUL2: begin
                    if (w_mul_done) begin
                        r_hi    <= w_hi;
                        r_lo    <= w_lo;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        if (r_hi) begin
                            r_rpm <= 16'h7fff;
                        end else if (r_lo) begin
                            r_rpm <= 16'h8000;
                        end else begin
                            r_rpm <= w_div_q ^ 16'h8000;
                        end
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_rpm  = r_rpm;

endmodule

// File: src/mecanum_wheel_speed_solver.sv
// top level of the mecanum wheel speed solver: ramp, frame rotation and wheel sequencing
//
// input channel (s_axis): one item per control tick with the target speeds,
// the spin rate and the gimbal angle; output channel (m_axis): one item with
// the four saturated wheel rpm commands for every input item.
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at the
// clock edge (ramp steps, wheelbase, track, offsets, rpm scale); indexes past
// the last register are ignored.
// an item passes the angle stage (two 16-step serial dividers for the table
// indexes), the four 24-step rotation multipliers, the wheel lanes (two
// 24-step multiplies and a 16-step divide) and the output register in turn.
// one item is worked on at a time; the next item is taken in the cycle after
// the result moves to the output register.
// reset clears the ramped speeds to zero and loads the register defaults.
// a stalled receiver holds the result in the output register; the block
// takes one more item and then waits with its finished result.
module mecanum_wheel_speed_solver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // target_vx[13:0], target_vy[27:14], spin_rate[41:28], gimbal_angle[57:42]
    input  logic [63:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // rpm_front_left[15:0], rpm_front_right[31:16], rpm_back_left[47:32],
    // rpm_back_right[63:48]
    output logic [63:0] o_m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);

    localparam int IDX_W = mwss_pkg::IDX_W;
    localparam int DEPTH = mwss_pkg::SINE_DEPTH;
    localparam int AW    = mwss_pkg::MUL_A_W;
    localparam int BW    = mwss_pkg::MUL_B_W;
    localparam int PW    = mwss_pkg::MUL_P_W;
    localparam int NW    = mwss_pkg::DIV_N_W;
    localparam int QW    = mwss_pkg::DIV_Q_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_INDEX,
        ST_ROT_GO,
        ST_ROT,
        ST_WHL_GO,
        ST_WHL,
        ST_DONE
    } t_state;

    // configuration registers
    logic [11:0]        r_step_x;
    logic [11:0]        r_step_y;
    logic [11:0]        r_wbase;
    logic [11:0]        r_wtrack;
    logic signed [10:0] r_ofs_x;
    logic signed [10:0] r_ofs_y;
    logic [23:0]        r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_x <= 12'd2;
            r_step_y <= 12'd2;
            r_wbase  <= '0;
            r_wtrack <= '0;
            r_ofs_x  <= '0;
            r_ofs_y  <= '0;
            r_scale  <= 24'd156456;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mwss_pkg::CFG_STEP_X: r_step_x <= i_cfg_data[11:0];
                mwss_pkg::CFG_STEP_Y: r_step_y <= i_cfg_data[11:0];
                mwss_pkg::CFG_WBASE:  r_wbase  <= i_cfg_data[11:0];
                mwss_pkg::CFG_WTRACK: r_wtrack <= i_cfg_data[11:0];
                mwss_pkg::CFG_OFS_X:  r_ofs_x  <= i_cfg_data[10:0];
                mwss_pkg::CFG_OFS_Y:  r_ofs_y  <= i_cfg_data[10:0];
                mwss_pkg::CFG_SCALE:  r_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic signed [13:0] f_ramp(
        input logic signed [13:0] cur,
        input logic signed [13:0] tgt,
        input logic [11:0]        step
    );
        logic signed [15:0] d;
        logic signed [15:0] s;
        d = 16'(tgt) - 16'(cur);
        s = $signed({4'b0, step});
        if (cur < tgt) begin
            return (d > s) ? 14'(16'(cur) + s) : tgt;
        end
        return (-d > s) ? 14'(16'(cur) - s) : tgt;
    endfunction

    function automatic logic [1:0] f_quad(input logic [15:0] a);
        if (a >= 16'd27000) return 2'd3;
        if (a >= 16'd18000) return 2'd2;
        if (a >= 16'd9000) return 2'd1;
        return 2'd0;
    endfunction

    function automatic logic [13:0] f_rem(input logic [15:0] a, input logic [1:0] q);
        logic [15:0] r;
        case (q)
            2'd0:    r = a;
            2'd1:    r = a - 16'd9000;
            2'd2:    r = a - 16'd18000;
            2'd3:    r = a - 16'd27000;
            default: r = a;
        endcase
        return r[13:0];
    endfunction

    function automatic logic signed [15:0] f_lookup(
        input logic [1:0]    q,
        input logic [QW-1:0] qd
    );
        logic [IDX_W-1:0] idx;
        logic [14:0]      v;
        idx = (qd > QW'(DEPTH)) ? IDX_W'(DEPTH) : qd[IDX_W-1:0];
        v   = q[0] ? mwss_pkg::SINE_TAB[IDX_W'(DEPTH) - idx] : mwss_pkg::SINE_TAB[idx];
        return q[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

    t_state             r_state;
    logic signed [13:0] r_rvx;
    logic signed [13:0] r_rvy;
    logic signed [13:0] r_spin;
    logic signed [15:0] r_ang;
    logic [1:0]         r_q_sin;
    logic [1:0]         r_q_cos;
    logic signed [15:0] r_sin;
    logic signed [15:0] r_cos;
    mwss_pkg::t_lane_cmd r_cmd [4];
    logic [15:0]        r_res [4];
    logic               r_out_valid;
    logic [63:0]        r_out_data;

    logic               w_in_acc;
    logic signed [13:0] w_in_vx;
    logic signed [13:0] w_in_vy;
    logic signed [16:0] w_wrap;
    logic [15:0]        w_a_sin;
    logic [15:0]        w_a_cos;
    logic [1:0]         w_qs;
    logic [1:0]         w_qc;
    logic [NW-1:0]      w_n_sin;
    logic [NW-1:0]      w_n_cos;
    logic               w_div_start;
    logic [1:0]         w_div_done;
    logic [QW-1:0]      w_q_sin;
    logic [QW-1:0]      w_q_cos;
    logic               w_rot_start;
    logic [3:0]         w_mul_done;
    logic signed [PW-1:0] w_p [4];
    logic signed [PW:0] w_vx_sum;
    logic signed [PW:0] w_vy_sum;
    logic signed [15:0] w_vx;
    logic signed [15:0] w_vy;
    logic signed [27:0] w_t_plus;
    logic signed [27:0] w_t_minus;
    logic signed [14:0] w_base;
    logic signed [14:0] w_ox2;
    logic signed [14:0] w_oy2;
    logic               w_lane_start;
    logic [3:0]         w_lane_done;
    logic [15:0]        w_lane_rpm [4];
    logic               w_out_free;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_vx         = i_s_axis_tdata[13:0];
    assign w_in_vy         = i_s_axis_tdata[27:14];

    // bring the angle into one turn, then split into quadrant and remainder
    assign w_wrap  = (r_ang < 0) ? (17'(r_ang) + 17'sd36000) : 17'(r_ang);
    assign w_a_sin = w_wrap[15:0];
    assign w_a_cos = (w_a_sin >= 16'd27000) ? (w_a_sin - 16'd27000) : (w_a_sin + 16'd9000);
    assign w_qs    = f_quad(w_a_sin);
    assign w_qc    = f_quad(w_a_cos);
    assign w_n_sin = NW'(f_rem(w_a_sin, w_qs)) * NW'(DEPTH) + NW'(4500);
    assign w_n_cos = NW'(f_rem(w_a_cos, w_qc)) * NW'(DEPTH) + NW'(4500);
    assign w_div_start = (r_state == ST_ANGLE);

    mwss_cdiv u_div_sin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_n     (w_n_sin),
        .i_d     (mwss_pkg::ANGLE_DIV),
        .o_done  (w_div_done[0]),
        .o_q     (w_q_sin)
    );

    mwss_cdiv u_div_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_n     (w_n_cos),
        .i_d     (mwss_pkg::ANGLE_DIV),
        .o_done  (w_div_done[1]),
        .o_q     (w_q_cos)
    );

    // rotation products: rvx*cos, rvy*sin, rvy*cos, rvx*sin
    assign w_rot_start = (r_state == ST_ROT_GO);

    mwss_smul u_mul_xc (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_rot_start),
        .i_a (AW'(r_rvx)), .i_b (BW'(r_cos)), .i_b_signed (1'b1),
        .o_done (w_mul_done[0]), .o_p (w_p[0])
    );

    mwss_smul u_mul_ys (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_rot_start),
        .i_a (AW'(r_rvy)), .i_b (BW'(r_sin)), .i_b_signed (1'b1),
        .o_done (w_mul_done[1]), .o_p (w_p[1])
    );

    mwss_smul u_mul_yc (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_rot_start),
        .i_a (AW'(r_rvy)), .i_b (BW'(r_cos)), .i_b_signed (1'b1),
        .o_done (w_mul_done[2]), .o_p (w_p[2])
    );

    mwss_smul u_mul_xs (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_rot_start),
        .i_a (AW'(r_rvx)), .i_b (BW'(r_sin)), .i_b_signed (1'b1),
        .o_done (w_mul_done[3]), .o_p (w_p[3])
    );

    // q15 sums rounded to nearest, ties up
    assign w_vx_sum  = (PW + 1)'(w_p[0]) + (PW + 1)'(w_p[1]) + (PW + 1)'(16384);
    assign w_vy_sum  = (PW + 1)'(w_p[2]) - (PW + 1)'(w_p[3]) + (PW + 1)'(16384);
    assign w_vx      = 16'(w_vx_sum >>> 15);
    assign w_vy      = 16'(w_vy_sum >>> 15);
    assign w_t_plus  = 28'(17'(w_vy) + 17'(w_vx)) * 28'sd2000;
    assign w_t_minus = 28'(17'(w_vy) - 17'(w_vx)) * 28'sd2000;

    // lever arms in half millimetres
    assign w_base = $signed(15'(r_wbase)) + $signed(15'(r_wtrack));
    assign w_ox2  = 15'(r_ofs_x) <<< 1;
    assign w_oy2  = 15'(r_ofs_y) <<< 1;

    assign w_lane_start = (r_state == ST_WHL_GO);

    for (genvar g = 0; g < 4; g++) begin : g_lane
        mwss_wheel u_wheel (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (w_lane_start),
            .i_cmd   (r_cmd[g]),
            .i_spin  (r_spin),
            .i_scale (r_scale),
            .o_done  (w_lane_done[g]),
            .o_rpm   (w_lane_rpm[g])
        );
    end

    assign w_out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rvx       <= '0;
            r_rvy       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_rvx   <= f_ramp(r_rvx, w_in_vx, r_step_x);
                        r_rvy   <= f_ramp(r_rvy, w_in_vy, r_step_y);
                        r_spin  <= i_s_axis_tdata[41:28];
                        r_ang   <= i_s_axis_tdata[57:42];
                        r_state <= ST_ANGLE;
                    end
                end
                ST_ANGLE: begin
                    r_q_sin <= w_qs;
                    r_q_cos <= w_qc;
                    r_state <= ST_INDEX;
                end
                ST_INDEX: begin
                    if (&w_div_done) begin
                        r_sin   <= f_lookup(r_q_sin, w_q_sin);
                        r_cos   <= f_lookup(r_q_cos, w_q_cos);
                        r_state <= ST_ROT_GO;
                    end
                end
                ST_ROT_GO: r_state <= ST_ROT;
                ST_ROT: begin
                    if (&w_mul_done) begin
                        r_cmd[0] <= '{term: w_t_plus, negate: 1'b0,
                                      lever: w_base - w_oy2 + w_ox2};
                        r_cmd[1] <= '{term: w_t_minus, negate: 1'b1,
                                      lever: w_base - w_oy2 - w_ox2};
                        r_cmd[2] <= '{term: w_t_minus, negate: 1'b0,
                                      lever: w_base + w_oy2 + w_ox2};
                        r_cmd[3] <= '{term: w_t_plus, negate: 1'b1,
                                      lever: w_base + w_oy2 - w_ox2};
                        r_state  <= ST_WHL_GO;
                    end
                end
                ST_WHL_GO: r_state <= ST_WHL;
                ST_WHL: begin
                    if (&w_lane_done) begin
                        for (int i = 0; i < 4; i++) begin
                            r_res[i] <= w_lane_rpm[i];
                        end
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out_data <= {r_res[3], r_res[2], r_res[1], r_res[0]};
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTH
    // all lanes run in lock step
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_lane_done) |-> (&w_lane_done))
        else $error("wheel lanes out of step");

    a_rot_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_mul_done) |-> (&w_mul_done))
        else $error("rotation multipliers out of step");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INDEX && w_div_done[0]) |->
            (w_q_sin <= QW'(DEPTH) && w_q_cos <= QW'(DEPTH)))
        else $error("sine index beyond table");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !i_m_axis_tready) |=> (r_state == ST_DONE))
        else $error("result dropped while output register full");
`endif

endmodule
